// ===== rtl/core/bcc_pkg.sv =====
`default_nettype none
package bcc_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_MS_W   = 16;

  localparam logic [CFG_MS_W-1:0] DEBOUNCE_MS_RST      = 16'd50;
  localparam logic [CFG_MS_W-1:0] MIN_CLICK_MS_RST     = 16'd45;
  localparam logic [CFG_MS_W-1:0] LONG_PRESS_MS_RST    = 16'd800;
  localparam logic [CFG_MS_W-1:0] DOUBLE_WINDOW_MS_RST = 16'd350;
  localparam logic [CFG_MS_W-1:0] BOOT_IGNORE_MS_RST   = 16'd3000;
  localparam logic                SINGLE_CLICK_EN_RST  = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_LONG   = 2'd1,
    ACT_SINGLE = 2'd2,
    ACT_DOUBLE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE      = 3'd0,
    REG_MIN_CLICK     = 3'd1,
    REG_LONG_PRESS    = 3'd2,
    REG_DOUBLE_WINDOW = 3'd3,
    REG_BOOT_IGNORE   = 3'd4,
    REG_SINGLE_EN     = 3'd5
  } reg_idx_t;

  localparam logic [1:0] CLICK_MAX = 2'd3;

  typedef struct packed {
    logic [CFG_MS_W-1:0] debounce_time;
    logic [CFG_MS_W-1:0] min_click_time;
    logic [CFG_MS_W-1:0] long_press_time;
    logic [CFG_MS_W-1:0] double_window_ms;
    logic [CFG_MS_W-1:0] boot_ignore_time;
    logic                single_click_enable;
  } cfg_t;

  typedef struct packed {
    logic              raw_level;
    logic [TIME_W-1:0] raw_change_time;
    logic              debounced_level;
    logic [TIME_W-1:0] press_start_time;
    logic [TIME_W-1:0] release_time;
    logic [1:0]        click_count;
  } state_t;

  localparam cfg_t CFG_RST = '{
    debounce_time:       DEBOUNCE_MS_RST,
    min_click_time:      MIN_CLICK_MS_RST,
    long_press_time:     LONG_PRESS_MS_RST,
    double_window_ms:    DOUBLE_WINDOW_MS_RST,
    boot_ignore_time:    BOOT_IGNORE_MS_RST,
    single_click_enable: SINGLE_CLICK_EN_RST
  };

  localparam state_t STATE_RST = '0;

endpackage
`default_nettype wire

// ===== rtl/core/bcc_if.sv =====
`default_nettype none
interface bcc_in_if;
  logic        valid;
  logic        ready;
  logic        button_down;
  logic [31:0] now_ms;

  modport source (output valid, output button_down, output now_ms, input ready);
  modport sink   (input valid, input button_down, input now_ms, output ready);
endinterface

interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic       stable_down;
  logic [1:0] action;

  modport source (output valid, output stable_down, output action, input ready);
  modport sink   (input valid, input stable_down, input action, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bcc_regs.sv =====
`default_nettype none
module bcc_regs import bcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE:      cfg_r.debounce_time       <= pwdata[CFG_MS_W-1:0];
        REG_MIN_CLICK:     cfg_r.min_click_time      <= pwdata[CFG_MS_W-1:0];
        REG_LONG_PRESS:    cfg_r.long_press_time     <= pwdata[CFG_MS_W-1:0];
        REG_DOUBLE_WINDOW: cfg_r.double_window_ms    <= pwdata[CFG_MS_W-1:0];
        REG_BOOT_IGNORE:   cfg_r.boot_ignore_time    <= pwdata[CFG_MS_W-1:0];
        REG_SINGLE_EN:     cfg_r.single_click_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DEBOUNCE:      prdata = {16'd0, cfg_r.debounce_time};
      REG_MIN_CLICK:     prdata = {16'd0, cfg_r.min_click_time};
      REG_LONG_PRESS:    prdata = {16'd0, cfg_r.long_press_time};
      REG_DOUBLE_WINDOW: prdata = {16'd0, cfg_r.double_window_ms};
      REG_BOOT_IGNORE:   prdata = {16'd0, cfg_r.boot_ignore_time};
      REG_SINGLE_EN:     prdata = {31'd0, cfg_r.single_click_enable};
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/bcc_step.sv =====
`default_nettype none
module bcc_step import bcc_pkg::*; (
  input  cfg_t              cfg,
  input  state_t            st,
  input  logic              down,
  input  logic [TIME_W-1:0] now,
  output state_t            st_nxt,
  output logic              stable_down,
  output action_t           action
);

  logic [TIME_W-1:0] rct_nxt;
  logic [TIME_W-1:0] since_raw;
  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] since_rel;
  logic              deb_fire;
  logic              in_boot;
  logic              counted;

  assign rct_nxt   = (down != st.raw_level) ? now : st.raw_change_time;
  assign since_raw = now - rct_nxt;
  assign held      = now - st.press_start_time;
  assign since_rel = now - st.release_time;
  assign deb_fire  = (since_raw >= {16'd0, cfg.debounce_time}) &&
                     (st.debounced_level != down);
  assign in_boot   = now < {16'd0, cfg.boot_ignore_time};

  always_comb begin
    st_nxt                 = st;
    st_nxt.raw_level       = down;
    st_nxt.raw_change_time = rct_nxt;
    action                 = ACT_NONE;
    counted                = 1'b0;

    if (deb_fire) begin
      st_nxt.debounced_level = down;
      if (in_boot) begin
        st_nxt.click_count = '0;
      end else if (down) begin
        st_nxt.press_start_time = now;
      end else if (held < {16'd0, cfg.min_click_time}) begin
        // bounce, nothing to do
      end else if (held >= {16'd0, cfg.long_press_time}) begin
        st_nxt.click_count = '0;
        action             = ACT_LONG;
      end else begin
        if (st.click_count != CLICK_MAX) st_nxt.click_count = st.click_count + 2'd1;
        st_nxt.release_time = now;
        counted             = 1'b1;
      end
    end

    // a click counted on this sample has a zero-length gap, so the window is still open
    if ((st_nxt.click_count != 2'd0) && !counted &&
        (since_rel > {16'd0, cfg.double_window_ms})) begin
      if (st_nxt.click_count >= 2'd2) action = ACT_DOUBLE;
      else if (cfg.single_click_enable) action = ACT_SINGLE;
      st_nxt.click_count = '0;
    end
  end

  assign stable_down = st_nxt.debounced_level;

endmodule
`default_nettype wire

// ===== rtl/core/button_click_classifier_core.sv =====
// Channel  Dir  Payload                       Handshake
// in_ch    in   button_down[0], now_ms[31:0]  valid/ready
// out_ch   out  stable_down[0], action[1:0]   valid/ready
// cfg      in   APB, paddr[4:0], 32b data     psel/penable, pready tied high
//
// One sample per clock sustained while out_ch is ready; a result reaches out_ch through
// the input register, then classify logic into the result register.
// Button state updates as a sample moves into the result register.
// rst_n is synchronous: clears both valid flags, button state and registers.
// A stalled out_ch holds the result; in_ch keeps accepting while the input
// register is empty or moving forward.
`default_nettype none
module button_click_classifier_core import bcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bcc_in_if.sink                in_ch,
  bcc_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t              cfg;
  state_t            state_r;
  state_t            state_nxt;
  logic              in_valid_r;
  logic              in_down_r;
  logic [TIME_W-1:0] in_now_r;
  logic              out_valid_r;
  logic              out_down_r;
  action_t           out_action_r;
  logic              out_down_nxt;
  action_t           out_action_nxt;
  logic              adv;

  bcc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcc_step u_step (
    .cfg         (cfg),
    .st          (state_r),
    .down        (in_down_r),
    .now         (in_now_r),
    .st_nxt      (state_nxt),
    .stable_down (out_down_nxt),
    .action      (out_action_nxt)
  );

  assign adv         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RST;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (adv) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_down_r <= in_ch.button_down;
      in_now_r  <= in_ch.now_ms;
    end
    if (adv) begin
      out_down_r   <= out_down_nxt;
      out_action_r <= out_action_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.stable_down = out_down_r;
  assign out_ch.action      = out_action_r;

endmodule
`default_nettype wire

// ===== rtl/core/bcc_checker.sv =====
`default_nettype none
module bcc_checker import bcc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_stable_down,
  input logic [1:0] out_action
);

  // a held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_stable_down) && $stable(out_action))
    else $error("result changed while stalled");

  // long press is decided on a release, so the level it reports is up
  a_long_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_LONG) |-> !out_stable_down)
    else $error("long press reported with button down");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input side only stalls when a result is waiting downstream
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

endmodule

bind button_click_classifier_core bcc_checker u_bcc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_stable_down (out_ch.stable_down),
  .out_action      (out_ch.action)
);
`default_nettype wire

// ===== sim/button_click_classifier_core_tb.sv =====
`timescale 1ns / 1ps

import bcc_pkg::*;

typedef struct packed {
  logic    stable_down;
  action_t action;
} click_result_t;

// Tracks the debounce/click state and holds the results still owed by the block.
class click_tracker;
  logic [15:0]   debounce;
  logic [15:0]   min_click;
  logic [15:0]   long_press;
  logic [15:0]   dbl_window;
  logic [15:0]   boot_ignore;
  logic          single_en;
  logic          raw_lvl;
  logic          deb_lvl;
  logic [31:0]   raw_t;
  logic [31:0]   press_t;
  logic [31:0]   rel_t;
  logic [1:0]    clicks;
  click_result_t expected[$];
  int            errors;

  function new();
    debounce    = DEBOUNCE_MS_RST;
    min_click   = MIN_CLICK_MS_RST;
    long_press  = LONG_PRESS_MS_RST;
    dbl_window  = DOUBLE_WINDOW_MS_RST;
    boot_ignore = BOOT_IGNORE_MS_RST;
    single_en   = SINGLE_CLICK_EN_RST;
    raw_lvl     = 1'b0;
    deb_lvl     = 1'b0;
    raw_t       = '0;
    press_t     = '0;
    rel_t       = '0;
    clicks      = '0;
    errors      = 0;
  endfunction

  function void set_reg(reg_idx_t idx, logic [31:0] val);
    case (idx)
      REG_DEBOUNCE:      debounce    = val[15:0];
      REG_MIN_CLICK:     min_click   = val[15:0];
      REG_LONG_PRESS:    long_press  = val[15:0];
      REG_DOUBLE_WINDOW: dbl_window  = val[15:0];
      REG_BOOT_IGNORE:   boot_ignore = val[15:0];
      REG_SINGLE_EN:     single_en   = val[0];
      default: ;
    endcase
  endfunction

  function void note_sample(logic down, logic [31:0] now);
    action_t       act;
    logic          was;
    logic [31:0]   since_change;
    logic [31:0]   held;
    logic [31:0]   since_release;
    click_result_t res;
    act = ACT_NONE;
    if (down != raw_lvl) begin
      raw_lvl = down;
      raw_t = now;
    end
    since_change = now - raw_t;
    if (since_change >= {16'd0, debounce} && deb_lvl != raw_lvl) begin
      was = deb_lvl;
      deb_lvl = raw_lvl;
      // boot period: absolute timestamp, no wrap
      if (now < {16'd0, boot_ignore}) begin
        clicks = '0;
      end else if (!was && deb_lvl) begin
        press_t = now;
      end else if (was && !deb_lvl) begin
        held = now - press_t;
        if (held < {16'd0, min_click}) begin
          // bounce, checked ahead of the long-press test
        end else if (held >= {16'd0, long_press}) begin
          clicks = '0;
          act = ACT_LONG;
        end else begin
          if (clicks < CLICK_MAX) clicks = clicks + 2'd1;
          rel_t = now;
        end
      end
    end
    since_release = now - rel_t;
    if (clicks != 0 && since_release > {16'd0, dbl_window}) begin
      if (clicks >= 2) act = ACT_DOUBLE;
      else if (single_en) act = ACT_SINGLE;
      clicks = '0;
    end
    res.stable_down = deb_lvl;
    res.action = act;
    expected.push_back(res);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_result(logic stable_down, logic [1:0] action);
    click_result_t exp;
    if (expected.size() == 0) begin
      report($sformatf("result with nothing expected (stable_down=%0b action=%0d)",
                       stable_down, action));
    end else begin
      exp = expected.pop_front();
      if (stable_down !== exp.stable_down)
        report($sformatf("stable_down %0b, expected %0b", stable_down, exp.stable_down));
      if (action !== exp.action)
        report($sformatf("action %0d, expected %0d", action, exp.action));
    end
  endtask
endclass

module button_click_classifier_core_tb;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bcc_in_if  in_if();
  bcc_out_if out_if();

  click_tracker tracker = new();

  logic [31:0] clock_ms;
  int          max_inc;
  int          n_sent = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  bit          hold_off_req = 1'b0;

  always #5 clk = ~clk;

  button_click_classifier_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  task automatic send_sample(input logic down, input logic [31:0] now);
    int gap;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.button_down <= down;
    in_if.now_ms      <= now;
    do @(posedge clk); while (!in_if.ready);
    tracker.note_sample(down, now);
    n_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (tracker.expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // upper data bits are don't-care for the block, so they get random junk
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    logic [31:0] word;
    word = {16'($urandom()), val};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, word);
  endtask

  task automatic configure(input logic [15:0] deb, input logic [15:0] minc,
                           input logic [15:0] lng, input logic [15:0] win,
                           input logic [15:0] boot, input logic en);
    int span;
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_MIN_CLICK, minc);
    write_reg(REG_LONG_PRESS, lng);
    write_reg(REG_DOUBLE_WINDOW, win);
    write_reg(REG_BOOT_IGNORE, boot);
    write_reg(REG_SINGLE_EN, {15'($urandom()), en});
    span = int'(deb);
    if (int'(minc) > span) span = int'(minc);
    if (int'(lng) > span) span = int'(lng);
    if (int'(win) > span) span = int'(win);
    max_inc = 1 + span / 12;
  endtask

  task automatic hold_level(input logic level, input int dur);
    int elapsed;
    int inc;
    elapsed = 0;
    do begin
      send_sample(level, clock_ms);
      inc = $urandom_range(1, max_inc);
      clock_ms = clock_ms + 32'(inc);
      elapsed += inc;
    end while (elapsed <= dur);
  endtask

  task automatic gen_press();
    int r;
    int n;
    int deb;
    int mc;
    int lp;
    int win;
    int hold;
    deb = int'(tracker.debounce);
    mc  = int'(tracker.min_click);
    lp  = int'(tracker.long_press);
    win = int'(tracker.dbl_window);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise: random levels, sometimes a jump anywhere on the time line
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + 32'($urandom_range(0, 3 * max_inc));
        send_sample(1'($urandom_range(0, 1)), clock_ms);
      end
    end else if (r < 18) begin
      // glitch: a random level, sampled for up to the debounce time
      hold_level(1'($urandom_range(0, 1)), $urandom_range(0, deb));
    end else begin
      case ($urandom_range(0, 2))
        0:       hold = $urandom_range(deb, mc);
        1:       hold = $urandom_range(mc, lp);
        default: hold = $urandom_range(lp, lp + lp / 4 + max_inc);
      endcase
      hold_level(1'b1, hold);
      hold_level(1'b0, deb + $urandom_range(0, 2 * win + max_inc));
    end
  endtask

  task automatic run_phase(input int n_items, input logic [31:0] start_ms);
    int stop_at;
    stop_at = n_sent + n_items;
    clock_ms = start_ms;
    while (n_sent < stop_at) gen_press();
    wait_idle();
  endtask

  function automatic logic [15:0] rand_ms();
    if ($urandom_range(0, 4) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 120));
  endfunction

  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 7);
      if (hold_off_req) begin
        stall = 300;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      tracker.check_result(out_if.stable_down, out_if.action);
    end
  end

  initial begin : stimulus
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.button_down = 1'b0;
    in_if.now_ms      = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    max_inc           = 1 + BOOT_IGNORE_MS_RST / 12;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: press and release inside the boot period
    send_sample(1'b1, 32'd0);
    send_sample(1'b1, 32'd60);
    send_sample(1'b0, 32'd200);
    send_sample(1'b0, 32'd260);
    // press taken during boot, release after it: timed from the old start
    send_sample(1'b1, 32'd2940);
    send_sample(1'b1, 32'd2990);
    send_sample(1'b0, 32'd3050);
    send_sample(1'b0, 32'd3100);
    // single click, resolved just past the window
    send_sample(1'b1, 32'd4000);
    send_sample(1'b1, 32'd4050);
    send_sample(1'b0, 32'd4200);
    send_sample(1'b0, 32'd4250);
    send_sample(1'b0, 32'd4601);
    // double click
    send_sample(1'b1, 32'd5000);
    send_sample(1'b1, 32'd5050);
    send_sample(1'b0, 32'd5150);
    send_sample(1'b0, 32'd5200);
    send_sample(1'b1, 32'd5210);
    send_sample(1'b1, 32'd5260);
    send_sample(1'b0, 32'd5360);
    send_sample(1'b0, 32'd5410);
    send_sample(1'b0, 32'd5761);
    // timestamp extremes, raw change across the wrap
    send_sample(1'b1, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'h0000_0000);
    wait_idle();

    configure(16'd4, 16'd12, 16'd60, 16'd30, 16'd100, 1'b1);
    run_phase(350, 32'd0);
    configure(16'd4, 16'd12, 16'd60, 16'd30, 16'd100, 1'b0);
    run_phase(200, 32'hFFFF_F000);
    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    run_phase(120, $urandom());
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    run_phase(200, 32'hFFFE_0000);
    // bounce limit above the long-press limit
    configure(16'd3, 16'd100, 16'd40, 16'd25, 16'd50, 1'b1);
    run_phase(120, 32'd0);

    for (int i = 0; i < 5; i++) begin
      configure(rand_ms(), rand_ms(), rand_ms(), rand_ms(), rand_ms(),
                1'($urandom_range(0, 1)));
      // receiver backs off for a long stretch while samples keep coming
      if (i == 1) hold_off_req = 1'b1;
      run_phase(150, ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom()));
    end

    repeat (10) @(posedge clk);
    if (tracker.expected.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.expected.size()));
    if (tracker.errors == 0) begin
      $display("button_click_classifier_core_tb OK");
    end else begin
      $display("button_click_classifier_core_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("button_click_classifier_core_tb NOT OK");
    $finish;
  end

endmodule
